// ===== rtl/core/assert_macros.svh =====
// assertion macros included by the congestion window unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/dacw_pkg.sv =====
// types and constants of the congestion window unit
package dacw_pkg;

	localparam int unsigned TABLE_DEPTH_DEF      = 64;
	localparam int unsigned WINDOW_FRAC_BITS_DEF = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_GAP        = 3'd4;

	localparam logic [7:0]  MAX_WINDOW_RST   = 8'd50;
	localparam logic [7:0]  MIN_WINDOW_RST   = 8'd1;
	localparam logic [15:0] DECREASE_RST     = 16'd36045;
	localparam logic [15:0] FLOOR_RST        = 16'd125;
	localparam logic [15:0] FAST_GAP_RST     = 16'd10;
	localparam logic [31:0] CUR_TIMEOUT_RST  = 32'd105;
	localparam logic [31:0] LOW_TIMEOUT_RST  = 32'd10000;

	localparam logic OP_SEND = 1'b0;
	localparam logic OP_ACK  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] seq_number;
		logic [31:0] send_time;
		logic [31:0] receiver_time;
		logic [31:0] ack_arrival_time;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  window_packets;
		logic [31:0] wait_timeout_ms;
		logic        congested;
		logic [1:0]  status;
	} out_item_t;

endpackage

// ===== rtl/core/dacw_div.sv =====
// restoring divider of a power-of-two numerator by the window, one bit per cycle
module dacw_div #(
	parameter int unsigned WW = 24,
	parameter int unsigned NW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          two,
	input  logic [WW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [WW-1:0] rem_q;
	logic [WW:0]   rem_t;
	logic [WW:0]   diff;
	logic          ge;

	assign rem_t = {rem_q, num_q[NW-1]};
	assign ge    = rem_t >= {1'b0, divisor};
	assign diff  = rem_t - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
			num_q  <= two ? {1'b1, {(NW-1){1'b0}}} : {2'b01, {(NW-2){1'b0}}};
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WW-1:0] : rem_t[WW-1:0];
			num_q <= {num_q[NW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ===== rtl/core/delay_aimd_congestion_window_unit.sv =====
// Sender-side congestion window unit: RTT/timeout estimator, outstanding-packet table and
// AIMD window. One event is taken at a time; in_stall stays high until its result is loaded
// into the output register, and the next event can be taken in the cycle after that. A send
// runs the table scan, at one entry per cycle through the table memory's read port, then
// writes its entry if a matching or free slot was found. An ack runs eight sequencer steps
// on the shared 32-bit adder and the timeout compare, the scan, then one multiply on
// congestion, a reload to the maximum window when the window is zero, or the bit-serial
// window divider otherwise. No clearing pass after reset is needed.
`include "assert_macros.svh"

module delay_aimd_congestion_window_unit #(
	parameter int unsigned TABLE_DEPTH      = dacw_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned WINDOW_FRAC_BITS = dacw_pkg::WINDOW_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dacw_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dacw_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dacw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dacw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dacw_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned F  = WINDOW_FRAC_BITS;
	localparam int unsigned WW = 8 + F;
	localparam int unsigned NW = 2 * F + 2;
	localparam int unsigned SW = NW + 1;
	localparam int unsigned PW = WW + 16;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RTT_DIFF, ST_RTT_ERR, ST_AVG, ST_ABS, ST_DEV_ERR, ST_DEV, ST_CUR,
		ST_LOW, ST_SCAN, ST_POST, ST_MUL, ST_SHIFT, ST_DIV, ST_CLAMP, ST_DONE
	} state_t;

	state_t            state_q;
	in_item_t          item_q;
	logic [31:0]       tmp_q;
	logic [31:0]       avg_q;
	logic [31:0]       dev_q;
	logic [31:0]       cur_q;
	logic [31:0]       low_q;
	logic [31:0]       last_rcv_q;
	logic [WW-1:0]     w_q;
	logic [SW-1:0]     wn_q;
	logic [PW-1:0]     prod_q;
	logic [7:0]        max_q;
	logic [7:0]        min_q;
	logic [15:0]       decr_q;
	logic [15:0]       floor_q;
	logic [15:0]       gap_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IW-1:0]     idx_q;
	logic              issue_q;
	logic              rd_vld_q;
	logic [IW-1:0]     rd_idx_q;
	logic [31:0]       rd_seq_q;
	logic [31:0]       rd_time_q;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic              free_q;
	logic [IW-1:0]     free_idx_q;
	logic              cong_q;
	logic [1:0]        status_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [31:0] mem_seq  [TABLE_DEPTH];
	logic [31:0] mem_time [TABLE_DEPTH];

	logic [31:0]   add_a, add_b, add_y;
	logic          add_sub;
	logic [31:0]   avg_sh, dev_sh, wt;
	logic [31:0]   lo_min, lo_next;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic          div_start, div_done, fast;
	logic [NW-1:0] div_quo;
	logic [SW-1:0] max_ext, min_ext, clamp_hi, clamp_lo;

	assign avg_sh = $unsigned($signed(avg_q) >>> 3);
	assign dev_sh = $unsigned($signed(dev_q) >>> 2);
	assign wt     = (low_q < cur_q) ? low_q : cur_q;

	// shared adder, operands picked by the sequencer
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_RTT_DIFF: begin
				add_a = item_q.ack_arrival_time; add_b = item_q.send_time; add_sub = 1'b1;
			end
			ST_RTT_ERR: begin
				add_a = tmp_q; add_b = avg_sh; add_sub = 1'b1;
			end
			ST_AVG: begin
				add_a = avg_q; add_b = tmp_q;
			end
			ST_ABS: begin
				add_b = tmp_q; add_sub = 1'b1;
			end
			ST_DEV_ERR: begin
				add_a = tmp_q; add_b = dev_sh; add_sub = 1'b1;
			end
			ST_DEV: begin
				add_a = dev_q; add_b = tmp_q;
			end
			ST_CUR: begin
				add_a = avg_sh; add_b = dev_q;
			end
			ST_SCAN: begin
				add_a = item_q.ack_arrival_time; add_b = rd_time_q; add_sub = 1'b1;
			end
			ST_POST: begin
				add_a = item_q.receiver_time; add_b = last_rcv_q; add_sub = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
		add_y = add_a + (add_sub ? ~add_b : add_b) + {31'b0, add_sub};
	end

	always_comb begin
		lo_min  = ($signed(cur_q) < $signed(low_q)) ? cur_q : low_q;
		lo_next = ($signed(lo_min) < $signed({16'b0, floor_q})) ? {16'b0, floor_q} : lo_min;
	end

	assign fast      = (last_rcv_q != '0) && (add_y <= {16'b0, gap_q});
	assign div_start = (state_q == ST_POST) && (item_q.opcode == OP_ACK) && !cong_q
		&& (w_q != '0);

	assign max_ext  = SW'({max_q, {F{1'b0}}});
	assign min_ext  = SW'({min_q, {F{1'b0}}});
	assign clamp_hi = (wn_q > max_ext) ? max_ext : wn_q;
	assign clamp_lo = (clamp_hi < min_ext) ? min_ext : clamp_hi;

	assign mem_we = (state_q == ST_POST) && (item_q.opcode == OP_SEND) && (hit_q || free_q);
	assign mem_wa = hit_q ? hit_idx_q : free_idx_q;

	dacw_div #(
		.WW(WW),
		.NW(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.two     (fast),
		.divisor (w_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// table memory, one read and one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_seq[mem_wa]  <= item_q.seq_number;
			mem_time[mem_wa] <= item_q.send_time;
		end
		rd_seq_q  <= mem_seq[idx_q];
		rd_time_q <= mem_time[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_WINDOW_RST;
			min_q   <= MIN_WINDOW_RST;
			decr_q  <= DECREASE_RST;
			floor_q <= FLOOR_RST;
			gap_q   <= FAST_GAP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_WINDOW:      max_q   <= cfg_data[7:0];
				CFG_MIN_WINDOW:      min_q   <= cfg_data[7:0];
				CFG_DECREASE_FACTOR: decr_q  <= cfg_data;
				CFG_TIMEOUT_FLOOR:   floor_q <= cfg_data;
				CFG_FAST_GAP:        gap_q   <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			tmp_q       <= '0;
			avg_q       <= '0;
			dev_q       <= '0;
			cur_q       <= CUR_TIMEOUT_RST;
			low_q       <= LOW_TIMEOUT_RST;
			last_rcv_q  <= '0;
			w_q         <= WW'(1) << F;
			wn_q        <= '0;
			prod_q      <= '0;
			valid_q     <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			rd_vld_q    <= 1'b0;
			rd_idx_q    <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			cong_q      <= 1'b0;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			rd_vld_q <= (state_q == ST_SCAN) && issue_q;
			rd_idx_q <= idx_q;
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q   <= in_data;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						cong_q   <= 1'b0;
						status_q <= STATUS_OK;
						idx_q    <= '0;
						issue_q  <= 1'b1;
						state_q  <= (in_data.opcode == OP_ACK) ? ST_RTT_DIFF : ST_SCAN;
					end
				end
				ST_RTT_DIFF: begin
					tmp_q   <= add_y;
					state_q <= ST_RTT_ERR;
				end
				ST_RTT_ERR: begin
					tmp_q   <= add_y;
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					avg_q   <= add_y;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					if (tmp_q[31]) begin
						tmp_q <= add_y;
					end
					state_q <= ST_DEV_ERR;
				end
				ST_DEV_ERR: begin
					tmp_q   <= add_y;
					state_q <= ST_DEV;
				end
				ST_DEV: begin
					dev_q   <= add_y;
					state_q <= ST_CUR;
				end
				ST_CUR: begin
					cur_q   <= add_y;
					state_q <= ST_LOW;
				end
				ST_LOW: begin
					low_q   <= lo_next;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (idx_q == IW'(TABLE_DEPTH - 1)) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					// memory data arrives in the cycle after its address
					if (rd_vld_q) begin
						if (valid_q[rd_idx_q]) begin
							if (rd_seq_q == item_q.seq_number && !hit_q) begin
								hit_q     <= 1'b1;
								hit_idx_q <= rd_idx_q;
							end
							if (item_q.opcode == OP_ACK && add_y > wt) begin
								cong_q <= 1'b1;
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_q;
						end
					end
					if (!issue_q && !rd_vld_q) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (item_q.opcode == OP_SEND) begin
						if (mem_we) begin
							valid_q[mem_wa] <= 1'b1;
						end else begin
							status_q <= STATUS_FULL;
						end
						state_q <= ST_DONE;
					end else begin
						if (hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
						end else begin
							status_q <= STATUS_UNKNOWN;
						end
						if (cong_q) begin
							state_q <= ST_MUL;
						end else if (w_q == '0) begin
							wn_q    <= max_ext;
							state_q <= ST_CLAMP;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= PW'(w_q) * PW'(decr_q);
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					wn_q    <= SW'(prod_q[PW-1:16]);
					state_q <= ST_CLAMP;
				end
				ST_DIV: begin
					if (div_done) begin
						wn_q    <= SW'(w_q) + SW'(div_quo);
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					w_q        <= clamp_lo[WW-1:0];
					last_rcv_q <= item_q.receiver_time;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q          <= 1'b1;
						out_q.window_packets <= w_q[F+7:F];
						out_q.wait_timeout_ms <= wt;
						out_q.congested      <= cong_q;
						out_q.status         <= status_q;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	`ASSERT_IMPL(a_rd_only_in_scan, clk, arst_n, rd_vld_q, state_q == ST_SCAN)
	`ASSERT_IMPL(a_div_done_in_div, clk, arst_n, div_done, state_q == ST_DIV)
	`ASSERT_NEXT(a_done_loads_out, clk, arst_n, state_q == ST_DONE && !(out_valid_q && out_stall), out_valid_q && state_q == ST_IDLE)
	`ASSERT_IMPL(a_full_not_cong, clk, arst_n, out_valid_q && out_q.status == STATUS_FULL, !out_q.congested)

endmodule

// ===== dv/delay_aimd_congestion_window_unit_test.sv =====
// testbench of the congestion window unit: directed and random events checked against a predictor
`timescale 1ns / 1ps

module delay_aimd_congestion_window_unit_test;
	import dacw_pkg::*;

	localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
	localparam int unsigned FRAC = WINDOW_FRAC_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE_CYCLES = 150;

	class window_scoreboard;
		bit [31:0] seq_e[DEPTH];
		bit [31:0] time_e[DEPTH];
		bit valid_e[DEPTH];
		bit [31:0] rtt_avg_x8, rtt_dev, cur_timeout, low_timeout, last_rcv;
		bit [63:0] window_q;
		bit [7:0] max_win, min_win;
		bit [15:0] factor, floor_ms, gap_ms;
		out_item_t expected_q[$];
		int unsigned mismatches;

		function new();
			foreach (valid_e[i]) valid_e[i] = 0;
			rtt_avg_x8 = 0;
			rtt_dev = 0;
			cur_timeout = CUR_TIMEOUT_RST;
			low_timeout = LOW_TIMEOUT_RST;
			window_q = 64'd1 << FRAC;
			last_rcv = 0;
			max_win = MAX_WINDOW_RST;
			min_win = MIN_WINDOW_RST;
			factor = DECREASE_RST;
			floor_ms = FLOOR_RST;
			gap_ms = FAST_GAP_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_MAX_WINDOW: max_win = val[7:0];
				CFG_MIN_WINDOW: min_win = val[7:0];
				CFG_DECREASE_FACTOR: factor = val;
				CFG_TIMEOUT_FLOOR: floor_ms = val;
				CFG_FAST_GAP: gap_ms = val;
				default: ;
			endcase
		endfunction

		function bit [31:0] wait_ms();
			return (low_timeout < cur_timeout) ? low_timeout : cur_timeout;
		endfunction

		function void note(in_item_t it);
			out_item_t r;
			int slot, free_slot, hit, lo;
			bit [31:0] d, wt;
			bit [63:0] k;
			r = '0;
			r.status = STATUS_OK;
			if (it.opcode == OP_SEND) begin
				slot = -1;
				free_slot = -1;
				for (int i = 0; i < DEPTH; i++) begin
					if (valid_e[i] && seq_e[i] == it.seq_number && slot < 0) slot = i;
					if (!valid_e[i] && free_slot < 0) free_slot = i;
				end
				if (slot < 0) slot = free_slot;
				if (slot < 0) begin
					r.status = STATUS_FULL;
				end else begin
					seq_e[slot] = it.seq_number;
					time_e[slot] = it.send_time;
					valid_e[slot] = 1;
				end
			end else begin
				d = (it.ack_arrival_time - it.send_time) - 32'($signed(rtt_avg_x8) >>> 3);
				rtt_avg_x8 += d;
				if (d[31]) d = -d;
				d = d - 32'($signed(rtt_dev) >>> 2);
				rtt_dev += d;
				cur_timeout = 32'($signed(rtt_avg_x8) >>> 3) + rtt_dev;
				lo = int'(low_timeout);
				if (int'(cur_timeout) < lo) lo = int'(cur_timeout);
				if (lo < int'({16'd0, floor_ms})) lo = int'({16'd0, floor_ms});
				low_timeout = 32'(lo);
				wt = wait_ms();
				hit = -1;
				for (int i = 0; i < DEPTH; i++) begin
					if (!valid_e[i]) continue;
					if (32'(it.ack_arrival_time - time_e[i]) > wt) r.congested = 1;
					if (seq_e[i] == it.seq_number && hit < 0) hit = i;
				end
				if (hit >= 0) valid_e[hit] = 0;
				else r.status = STATUS_UNKNOWN;
				if (r.congested) begin
					window_q = (window_q * factor) >> 16;
				end else begin
					k = 1;
					if (last_rcv != 0 && 32'(it.receiver_time - last_rcv) <= {16'd0, gap_ms})
						k = 2;
					if (window_q == 0) window_q = 64'(max_win) << FRAC;
					else window_q += (k << (2 * FRAC)) / window_q;
				end
				if (window_q > (64'(max_win) << FRAC)) window_q = 64'(max_win) << FRAC;
				if (window_q < (64'(min_win) << FRAC)) window_q = 64'(min_win) << FRAC;
				window_q &= (64'd1 << (8 + FRAC)) - 1;
				last_rcv = it.receiver_time;
			end
			r.window_packets = 8'(window_q >> FRAC);
			r.wait_timeout_ms = wait_ms();
			expected_q.push_back(r);
		endfunction

		function void check(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.window_packets !== want.window_packets
					|| got.wait_timeout_ms !== want.wait_timeout_ms
					|| got.congested !== want.congested || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	window_scoreboard sb = new();
	int unsigned cycles = 0;
	int unsigned out_hold = 0;
	bit quiet = 0;
	bit [31:0] now_ms = 1;
	bit [31:0] rcv_ms = 1;
	bit [31:0] next_seq = 100;

	delay_aimd_congestion_window_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** delay_aimd_congestion_window_unit: FAILED **");
			$finish;
		end
	end

	// result side: check the transfer, then draw the next stall length
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check(out_data);
			out_hold = quiet ? 0 : $urandom_range(0, 3);
		end
	end

	always @(negedge clk) begin
		if (out_hold > 0 && out_valid) begin
			out_stall = 1'b1;
			out_hold--;
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic push_event(in_item_t it);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		sb.note(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(bit [15:0] mx, bit [15:0] mn, bit [15:0] fac, bit [15:0] flr,
			bit [15:0] gp);
		drain();
		write_reg(CFG_MAX_WINDOW, mx);
		write_reg(CFG_MIN_WINDOW, mn);
		write_reg(CFG_DECREASE_FACTOR, fac);
		write_reg(CFG_TIMEOUT_FLOOR, flr);
		write_reg(CFG_FAST_GAP, gp);
	endtask

	function automatic in_item_t mk(logic op, bit [31:0] seq, bit [31:0] snt, bit [31:0] rcv,
			bit [31:0] arr);
		in_item_t it;
		it.opcode = op;
		it.seq_number = seq;
		it.send_time = snt;
		it.receiver_time = rcv;
		it.ack_arrival_time = arr;
		return it;
	endfunction

	task automatic send_new();
		now_ms += $urandom_range(0, 20);
		push_event(mk(OP_SEND, next_seq, now_ms, $urandom, $urandom));
		next_seq++;
	endtask

	// one random event; mostly well-formed traffic against the live table
	task automatic random_event();
		int unsigned pick, start, idx;
		int found;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			push_event(mk(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom));
			return;
		end
		found = -1;
		start = $urandom_range(0, DEPTH - 1);
		for (int i = 0; i < DEPTH; i++) begin
			idx = (start + i) % DEPTH;
			if (sb.valid_e[idx] && found < 0) found = idx;
		end
		if (found < 0 || pick < 50) begin
			if (pick < 14 && found >= 0)
				push_event(mk(OP_SEND, sb.seq_e[found], now_ms, $urandom, $urandom));
			else
				send_new();
		end else begin
			now_ms += ($urandom_range(0, 30) == 0) ? $urandom_range(0, 3000)
				: $urandom_range(0, 40);
			rcv_ms += $urandom_range(0, 25);
			if (pick > 95)
				push_event(mk(OP_ACK, next_seq + 1000, sb.time_e[found], rcv_ms, now_ms));
			else
				push_event(mk(OP_ACK, sb.seq_e[found], sb.time_e[found], rcv_ms, now_ms));
		end
	endtask

	task automatic random_phase(int unsigned n);
		// fill the table past full, then mixed traffic
		repeat (DEPTH + 2) send_new();
		for (int unsigned i = 0; i < n; i++) begin
			quiet = (i % 150) < 30;
			random_event();
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAX_WINDOW;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: duplicate send, first ack, wrapped times, unknown ack, congestion
		push_event(mk(OP_SEND, 32'd0, 32'd0, 32'd0, 32'd0));
		push_event(mk(OP_SEND, 32'd0, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_event(mk(OP_ACK, 32'd0, 32'd5, 32'd100, 32'd20));
		push_event(mk(OP_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0));
		push_event(mk(OP_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd105, 32'd3));
		push_event(mk(OP_ACK, 32'd1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_event(mk(OP_SEND, 32'd7, 32'd1000, 32'd0, 32'd0));
		push_event(mk(OP_SEND, 32'd8, 32'd1001, 32'd0, 32'd0));
		push_event(mk(OP_ACK, 32'd8, 32'd1001, 32'd110, 32'd100000));
		push_event(mk(OP_ACK, 32'd7, 32'd1000, 32'd111, 32'd100001));
		push_event(mk(OP_ACK, 32'd9, 32'd0, 32'h8000_0000, 32'h8000_0000));
		push_event(mk(OP_ACK, 32'd9, 32'h8000_0000, 32'h8000_0005, 32'd0));
		// let the result side catch up completely once
		drain();
		now_ms = 200000;
		rcv_ms = 200000;

		random_phase(330);
		configure(16'd255, 16'd1, 16'hFFFF, 16'd0, 16'd0);
		random_phase(330);
		configure(16'd1, 16'd255, 16'd0, 16'hFFFF, 16'hFFFF);
		random_phase(250);
		// zero window reachable with a zero lower clamp and zero factor
		configure(16'd255, 16'd0, 16'd0, 16'd125, 16'd10);
		random_phase(250);
		configure(16'($urandom_range(1, 255)), 16'($urandom_range(1, 40)), 16'($urandom),
			16'($urandom_range(0, 300)), 16'($urandom_range(0, 30)));
		random_phase(330);
		configure(16'd0, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(150);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** delay_aimd_congestion_window_unit: PASSED **");
		else
			$display("** delay_aimd_congestion_window_unit: FAILED **");
		$finish;
	end

endmodule
